// ===== hw/rtl/cvfp_pkg.sv =====
package cvfp_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int DEST_W = 5;
  localparam int DATA_W = 16;
  localparam int ADDR_W = 6;
  localparam int ID_W = DEST_W + ADDR_W;
  localparam int DLC_W = 4;

  localparam logic [DLC_W-1:0] DLC_SINGLE = 4'd4;
  localparam logic [DLC_W-1:0] DLC_MORE = 4'd8;
  localparam logic [DLC_W-1:0] DLC_LAST = 4'd9;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_REQ  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_FRAME    = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_RD3
  } state_t;

  typedef struct packed {
    logic [DEST_W-1:0] dest;
    logic [DATA_W-1:0] index;
    logic [DATA_W-1:0] value;
  } entry_t;

  typedef struct packed {
    op_t    op;
    entry_t ent;
  } cmd_t;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   frame_id;
    logic [DLC_W-1:0]  frame_dlc;
    logic [DATA_W-1:0] first_index;
    logic [DATA_W-1:0] first_value;
    logic [DATA_W-1:0] second_index;
    logic [DATA_W-1:0] second_value;
  } res_t;

endpackage

// ===== hw/rtl/cvfp_ram.sv =====
module cvfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/cvfp_front.sv =====
module cvfp_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       req_type,
  input  logic [cvfp_pkg::DEST_W-1:0] dest,
  input  logic [cvfp_pkg::DATA_W-1:0] data_index,
  input  logic [cvfp_pkg::DATA_W-1:0] data_value,
  output logic                       cmd_valid,
  output cvfp_pkg::cmd_t             cmd,
  input  logic                       cmd_pop
);
  import cvfp_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  cmd_t       cmd_in;

  assign in_ready  = (fill != 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push      = in_valid && in_ready;

  always_comb begin
    cmd_in.op        = req_type ? OP_REQ : OP_PUSH;
    cmd_in.ent.dest  = dest;
    cmd_in.ent.index = data_index;
    cmd_in.ent.value = data_value;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, cmd_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== hw/rtl/cvfp_back.sv =====
module cvfp_back #(
  parameter int QUEUE_DEPTH = cvfp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  input  cvfp_pkg::cmd_t              cmd,
  output logic                        cmd_pop,
  input  logic                        cfg_we,
  input  logic [cvfp_pkg::ADDR_W-1:0] cfg_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cvfp_pkg::res_t              res
);
  import cvfp_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic res_t make_frame(input entry_t a, input entry_t b, input logic two,
                                      input logic [DLC_W-1:0] dlc,
                                      input logic [ADDR_W-1:0] own);
    res_t r;
    r.status       = ST_FRAME;
    r.frame_id     = {a.dest, own};
    r.frame_dlc    = two ? dlc : DLC_SINGLE;
    r.first_index  = a.index;
    r.first_value  = a.value;
    r.second_index = two ? b.index : '0;
    r.second_value = two ? b.value : '0;
    return r;
  endfunction

  state_t            state, state_next;
  logic [AW-1:0]     head, head_next;
  logic [AW-1:0]     tail, tail_next;
  logic [CW-1:0]     count, count_next;
  logic [AW-1:0]     head1, head2;
  entry_t            first, first_next;
  entry_t            second, second_next;
  logic [ADDR_W-1:0] own_addr;
  logic              out_valid_next;
  res_t              res_next;
  logic              ram_we;
  logic [AW-1:0]     raddr;
  entry_t            rdata;
  logic [$bits(entry_t)-1:0] rdata_raw;

  assign head1 = wrap_inc(head);
  assign head2 = wrap_inc(head1);
  assign rdata = entry_t'(rdata_raw);

  cvfp_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tail),
    .wdata(cmd.ent),
    .raddr(raddr),
    .rdata(rdata_raw)
  );

  always_comb begin
    state_next     = state;
    head_next      = head;
    tail_next      = tail;
    count_next     = count;
    first_next     = first;
    second_next    = second;
    res_next       = res;
    out_valid_next = out_valid && !out_ready;
    cmd_pop        = 1'b0;
    ram_we         = 1'b0;
    raddr          = head;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid && !out_valid) begin
          cmd_pop  = 1'b1;
          res_next = '0;
          if (cmd.op == OP_PUSH) begin
            if (count == CW'(QUEUE_DEPTH)) begin
              res_next.status = ST_DROPPED;
            end else begin
              ram_we          = 1'b1;
              tail_next       = wrap_inc(tail);
              count_next      = count + CW'(1);
              res_next.status = ST_ACCEPTED;
            end
            out_valid_next = 1'b1;
          end else if (count == '0) begin
            res_next.status = ST_EMPTY;
            out_valid_next  = 1'b1;
          end else begin
            state_next = S_RD1;
          end
        end
      end
      S_RD1: begin
        first_next = rdata;
        if (count > CW'(1)) begin
          raddr      = head1;
          state_next = S_RD2;
        end else begin
          res_next       = make_frame(rdata, rdata, 1'b0, DLC_SINGLE, own_addr);
          head_next      = head1;
          count_next     = count - CW'(1);
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_RD2: begin
        if (rdata.dest == first.dest) begin
          second_next = rdata;
          if (count > CW'(2)) begin
            raddr      = head2;
            state_next = S_RD3;
          end else begin
            res_next       = make_frame(first, rdata, 1'b1, DLC_LAST, own_addr);
            head_next      = head2;
            count_next     = count - CW'(2);
            out_valid_next = 1'b1;
            state_next     = S_IDLE;
          end
        end else begin
          res_next       = make_frame(first, rdata, 1'b0, DLC_SINGLE, own_addr);
          head_next      = head1;
          count_next     = count - CW'(1);
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_RD3: begin
        res_next = make_frame(first, second, 1'b1,
                              (rdata.dest == first.dest) ? DLC_MORE : DLC_LAST, own_addr);
        head_next      = head2;
        count_next     = count - CW'(2);
        out_valid_next = 1'b1;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      own_addr  <= '0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        own_addr <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    first  <= first_next;
    second <= second_next;
    res    <= res_next;
  end

endmodule

// ===== hw/rtl/can_index_value_frame_packer.sv =====
// A push result is registered once the item is accepted; a frame request steps through
// S_RD1 to S_RD3, reading up to three triples from the single-port-read queue RAM.
// The back-end sequencer takes a new command only after its previous result has been
// taken at the output; a 2-entry command queue lets the input keep accepting meanwhile.
// Reset (rst, synchronous, active high) empties the queue and clears own_address;
// the triple RAM contents are not cleared.
module can_index_value_frame_packer #(
  parameter int QUEUE_DEPTH = cvfp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        req_type,
  input  logic [cvfp_pkg::DEST_W-1:0] dest,
  input  logic [cvfp_pkg::DATA_W-1:0] data_index,
  input  logic [cvfp_pkg::DATA_W-1:0] data_value,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cvfp_pkg::ADDR_W-1:0] own_address,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [cvfp_pkg::ID_W-1:0]   frame_id,
  output logic [cvfp_pkg::DLC_W-1:0]  frame_dlc,
  output logic [cvfp_pkg::DATA_W-1:0] first_index,
  output logic [cvfp_pkg::DATA_W-1:0] first_value,
  output logic [cvfp_pkg::DATA_W-1:0] second_index,
  output logic [cvfp_pkg::DATA_W-1:0] second_value
);
  import cvfp_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  res_t res;

  assign cfg_ready = 1'b1;

  cvfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .dest      (dest),
    .data_index(data_index),
    .data_value(data_value),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  cvfp_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (own_address),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .res      (res)
  );

  assign status       = res.status;
  assign frame_id     = res.frame_id;
  assign frame_dlc    = res.frame_dlc;
  assign first_index  = res.first_index;
  assign first_value  = res.first_value;
  assign second_index = res.second_index;
  assign second_value = res.second_value;

endmodule
